[rtl/tsb_pkg.sv]
`timescale 1ns / 1ps
package tsb_pkg;
  localparam int SB = 24;
  localparam int FB = 16;
  localparam logic [FB:0] ONE_Q = {1'b1, {FB{1'b0}}};
  localparam int QDEPTH = 4;

  typedef enum logic [1:0] {
    K_ZERO  = 2'd0,
    K_LOW   = 2'd1,
    K_HIGH  = 2'd2,
    K_BLEND = 2'd3
  } kind_t;

  // One classified item as it travels from the front part to the back part.
  typedef struct packed {
    kind_t                kind;
    logic signed [SB-1:0] low;
    logic signed [SB-1:0] high;
    logic [SB:0]          num;
    logic [SB:0]          den;
  } job_t;
endpackage

[rtl/threshold_smootherstep_blend.sv]
`timescale 1ns / 1ps
// out_strobe rises for an item once it has passed the front register, the queue and the back pipeline;
// one item accepted every cycle.
// The result path is a fixed pipeline (16 divider steps, four multiplies).
// The queue between classifier and pipeline never fills since the receiver
// cannot stall, so busy stays low after reset.
// Synchronous active-low reset clears threshold, falloff and all valid bits.
module threshold_smootherstep_blend import tsb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [SB-1:0] in_control_value,
  input  logic signed [SB-1:0] in_low_value,
  input  logic signed [SB-1:0] in_high_value,
  input  logic                 in_sources_present,
  output logic                 out_strobe,
  output logic signed [SB-1:0] out_blended_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [SB-1:0]        cfg_data
);
  logic signed [SB-1:0] thr_r;
  logic [SB-2:0] fo_r;
  logic take, jv, ne, room;
  job_t j, qj;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0; fo_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == 1'b0) thr_r <= cfg_data;
      else fo_r <= cfg_data[SB-2:0];
    end
  end

  assign cfg_ready = 1'b1;
  assign busy = !room;
  assign take = start && room;

  tsb_front u_front (.clk, .rst_n, .take, .threshold(thr_r), .falloff(fo_r),
    .ctrl(in_control_value), .low(in_low_value), .high(in_high_value),
    .present(in_sources_present), .job_vld(jv), .job(j));

  tsb_fifo u_q (.clk, .rst_n, .push(jv), .din(j), .pop(ne), .nonempty(ne),
    .room, .dout(qj));

  tsb_back u_back (.clk, .rst_n, .go(ne), .job(qj), .res_vld(out_strobe),
    .res(out_blended_value));
endmodule

[rtl/tsb_front.sv]
`timescale 1ns / 1ps
module tsb_front import tsb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic signed [SB-1:0] threshold,
  input  logic [SB-2:0]        falloff,
  input  logic signed [SB-1:0] ctrl,
  input  logic signed [SB-1:0] low,
  input  logic signed [SB-1:0] high,
  input  logic                 present,
  output logic                 job_vld,
  output job_t                 job
);
  logic signed [SB+1:0] lower, upper, c;
  job_t job_nxt, job_r;
  logic vld_r;

  always_comb begin
    c     = {{2{ctrl[SB-1]}}, ctrl};
    lower = {{2{threshold[SB-1]}}, threshold} - {3'b000, falloff};
    upper = {{2{threshold[SB-1]}}, threshold} + {3'b000, falloff};
    job_nxt.low  = low;
    job_nxt.high = high;
    job_nxt.num  = (SB+1)'(c - lower);
    job_nxt.den  = {1'b0, falloff, 1'b0};
    if (!present) job_nxt.kind = K_ZERO;
    else if (falloff != '0) begin
      if (c < lower) job_nxt.kind = K_LOW;
      else if (c > upper) job_nxt.kind = K_HIGH;
      else job_nxt.kind = K_BLEND;
    end else job_nxt.kind = (ctrl >= threshold) ? K_HIGH : K_LOW;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= take;
    job_r <= job_nxt;
  end

  assign job_vld = vld_r;
  assign job     = job_r;
endmodule

[rtl/tsb_fifo.sv]
`timescale 1ns / 1ps
module tsb_fifo import tsb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  input  logic pop,
  output logic nonempty,
  output logic room,
  output job_t dout
);
  localparam int AW = $clog2(QDEPTH);
  job_t mem [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem[wp_r] <= din;
  end

  assign nonempty = cnt_r != '0;
  assign room     = cnt_r < (AW+1)'(QDEPTH - 2);
  assign dout     = mem[rp_r];
endmodule

[rtl/tsb_back.sv]
`timescale 1ns / 1ps
module tsb_back import tsb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  job_t                 job,
  output logic                 res_vld,
  output logic signed [SB-1:0] res
);
  localparam int NS = FB + 6;
  // Pipeline: 16 divider steps, then f, f^2, f^3 with inner, product, lerp and output.
  logic [NS-1:0] v_r;
  job_t jb_r [NS];
  logic [SB:0] rem_r [FB+1];
  logic [FB:0] q_r [FB+1];
  logic [FB:0] f_r, f2_r, f3_r, b_r;
  logic [FB+3:0] inn_r;
  logic [FB:0] fa_r;
  logic [2*FB+1:0] p2, p3;
  logic [2*FB+4:0] pb;
  logic [SB:0] mag;
  logic [SB+FB+1:0] pm;
  logic signed [SB+1:0] sum;
  logic signed [SB-1:0] res_r;
  logic [SB+1:0] dsh [FB];
  logic [FB+4:0] inx;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[NS-2:0], go};
  end

  always_comb begin
    for (int i = 0; i < FB; i++) dsh[i] = {rem_r[i], 1'b0};
  end

  always_ff @(posedge clk) begin
    jb_r[0]  <= job;
    rem_r[0] <= job.num;
    q_r[0]   <= (job.num >= job.den) ? ONE_Q : '0;
    for (int i = 1; i < NS; i++) jb_r[i] <= jb_r[i-1];
    for (int i = 0; i < FB; i++) begin
      if (q_r[i][FB]) begin
        rem_r[i+1] <= rem_r[i];
        q_r[i+1]   <= q_r[i];
      end else if (dsh[i] >= {1'b0, jb_r[i].den}) begin
        rem_r[i+1] <= (SB+1)'(dsh[i] - {1'b0, jb_r[i].den});
        q_r[i+1]   <= {q_r[i][FB-1:0], 1'b1};
      end else begin
        rem_r[i+1] <= dsh[i][SB:0];
        q_r[i+1]   <= {q_r[i][FB-1:0], 1'b0};
      end
    end
    f_r  <= q_r[FB];
    f2_r <= (FB+1)'(p2 >> FB);
    fa_r <= f_r;
    f3_r <= (FB+1)'(p3 >> FB);
    inn_r <= (inx > (FB+5)'(15 * fa_r)) ? (FB+4)'(inx - (FB+5)'(15 * fa_r)) : '0;
    b_r  <= (f3_r == '0) ? '0 : ((pb >> FB) > (2*FB+5)'(ONE_Q) ? ONE_Q
                                  : (FB+1)'(pb >> FB));
    unique case (jb_r[NS-2].kind)
      K_ZERO:  res_r <= '0;
      K_LOW:   res_r <= jb_r[NS-2].low;
      K_HIGH:  res_r <= jb_r[NS-2].high;
      K_BLEND: begin
        if (sum > $signed({3'b000, {(SB-1){1'b1}}})) res_r <= {1'b0, {(SB-1){1'b1}}};
        else if (sum < -$signed({3'b000, {(SB-1){1'b1}}}) - 1)
          res_r <= {1'b1, {(SB-1){1'b0}}};
        else res_r <= SB'(sum);
      end
      default: res_r <= '0;
    endcase
  end

  // f3 of the f == 0 case is 0, and f == 1 gives f3 = 1 and inner = 1.
  always_comb begin
    logic signed [SB:0] d;
    p2  = f_r * f_r;
    p3  = f2_r * fa_r;
    inx = (FB+5)'(6 * f2_r) + (FB+5)'(10 * ONE_Q);
    pb  = f3_r * inn_r;
    d   = $signed({jb_r[NS-2].high[SB-1], jb_r[NS-2].high})
        - $signed({jb_r[NS-2].low[SB-1], jb_r[NS-2].low});
    mag = d[SB] ? (SB+1)'(-d) : (SB+1)'(d);
    pm  = mag * b_r;
    sum = $signed({{2{jb_r[NS-2].low[SB-1]}}, jb_r[NS-2].low})
        + (d[SB] ? -$signed({1'b0, (SB+1)'(pm >> FB)})
                 :  $signed({1'b0, (SB+1)'(pm >> FB)}));
  end

  assign res_vld = v_r[NS-1];
  assign res     = res_r;
endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
  import tsb_pkg::*;

  class blend_scoreboard;
    longint threshold;
    longint falloff;
    logic signed [SB-1:0] blend_q[$];
    int errors;
    int results_seen;

    function new();
      threshold = 0;
      falloff = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic idx, logic [SB-1:0] data);
      if (idx == 1'b0) threshold = longint'($signed(data));
      else falloff = longint'(data[SB-2:0]);
    endfunction

    function logic signed [SB-1:0] crossfade(logic signed [SB-1:0] ctrl_s,
                                             logic signed [SB-1:0] low_s,
                                             logic signed [SB-1:0] high_s,
                                             logic present);
      longint c, lo, hi, lower, upper, diff, res;
      longint unsigned num, den, rem, fq, f2, f3, inner, b, mag, term;
      longint lim;
      c = ctrl_s;
      lo = low_s;
      hi = high_s;
      lim = (64'sd1 <<< (SB - 1));
      if (!present) return '0;
      if (falloff == 0) return (c >= threshold) ? high_s : low_s;
      lower = threshold - falloff;
      upper = threshold + falloff;
      if (c < lower) return low_s;
      if (c > upper) return high_s;
      num = c - lower;
      den = upper - lower;
      // Position in the band as a truncated fraction, 1.0 at the upper edge.
      if (num >= den) begin
        fq = 64'd1 << FB;
      end else begin
        fq = 0;
        rem = num;
        for (int i = 0; i < FB; i++) begin
          rem = rem << 1;
          fq = fq << 1;
          if (rem >= den) begin
            rem = rem - den;
            fq = fq | 64'd1;
          end
        end
      end
      if (fq == 0) begin
        b = 0;
      end else if (fq >= (64'd1 << FB)) begin
        b = 64'd1 << FB;
      end else begin
        f2 = (fq * fq) >> FB;
        f3 = (f2 * fq) >> FB;
        inner = 6 * f2 + 10 * (64'd1 << FB);
        inner = (inner > 15 * fq) ? inner - 15 * fq : 0;
        b = (f3 * inner) >> FB;
        if (b > (64'd1 << FB)) b = 64'd1 << FB;
      end
      diff = hi - lo;
      mag = (diff < 0) ? -diff : diff;
      term = (mag * b) >> FB;
      res = lo + ((diff < 0) ? -longint'(term) : longint'(term));
      if (res > lim - 1) res = lim - 1;
      if (res < -lim) res = -lim;
      return res[SB-1:0];
    endfunction

    function void note_item(logic signed [SB-1:0] ctrl_s, logic signed [SB-1:0] low_s,
                            logic signed [SB-1:0] high_s, logic present);
      blend_q.push_back(crossfade(ctrl_s, low_s, high_s, present));
    endfunction

    function void check_result(logic signed [SB-1:0] got);
      logic signed [SB-1:0] want;
      results_seen++;
      if (blend_q.size() == 0) begin
        $error("blended_value: no item pending, actual %0d", got);
        errors++;
        return;
      end
      want = blend_q.pop_front();
      if (got !== want) begin
        $error("blended_value: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [SB-1:0] in_control_value;
  logic signed [SB-1:0] in_low_value;
  logic signed [SB-1:0] in_high_value;
  logic in_sources_present;
  logic out_strobe;
  logic signed [SB-1:0] out_blended_value;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [SB-1:0] cfg_data;

  blend_scoreboard sb;
  int burst_left;
  int cfg_writes;

  threshold_smootherstep_blend dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_blended_value);
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Keeps start high through a burst; lowers it only for a gap.
  task automatic send_item(logic signed [SB-1:0] c, logic signed [SB-1:0] lo,
                           logic signed [SB-1:0] hi, logic p);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (burst_left == 0) burst_left = 1;
    end
    burst_left--;
    start <= 1'b1;
    in_control_value <= c;
    in_low_value <= lo;
    in_high_value <= hi;
    in_sources_present <= p;
    do @(posedge clk); while (busy);
    sb.note_item(c, lo, hi, p);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.blend_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [SB-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    return SB'($urandom());
  endfunction

  // Control values mostly land in or near the blend band.
  function automatic logic signed [SB-1:0] rand_control();
    longint span, v;
    if ($urandom_range(0, 3) == 0) return SB'($urandom());
    span = 2 * sb.falloff + 4;
    v = sb.threshold + longint'($urandom_range(0, 32'(2 * span))) - span;
    return v[SB-1:0];
  endfunction

  task automatic directed_band();
    longint t, f;
    logic signed [SB-1:0] lo_edge, hi_edge, mid;
    t = sb.threshold;
    f = sb.falloff;
    lo_edge = SB'(t - f);
    hi_edge = SB'(t + f);
    mid = SB'(t);
    send_item(lo_edge, 24'sh800000, 24'sh7fffff, 1'b1);
    send_item(hi_edge, 24'sh800000, 24'sh7fffff, 1'b1);
    send_item(SB'(lo_edge - 1), 24'sh123456, -24'sh123456, 1'b1);
    send_item(SB'(hi_edge + 1), 24'sh123456, -24'sh123456, 1'b1);
    send_item(mid, 24'sh7fffff, 24'sh800000, 1'b1);
    send_item(mid, 24'sh7fffff, 24'sh800000, 1'b0);
    send_item(24'sh7fffff, 24'sh010000, 24'sh020000, 1'b1);
    send_item(24'sh800000, 24'sh010000, 24'sh020000, 1'b1);
  endtask

  initial begin
    logic [SB-1:0] thr_set[6];
    logic [SB-1:0] fall_set[6];
    sb = new();
    burst_left = 0;
    cfg_writes = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_control_value = '0;
    in_low_value = '0;
    in_high_value = '0;
    in_sources_present = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    thr_set = '{24'h000000, 24'h000000, 24'h7fffff, 24'h800000, 24'h000000, 24'h000000};
    fall_set = '{24'h000000, 24'h010000, 24'hffffff, 24'h000001, 24'h400000, 24'h008000};
    thr_set[4] = SB'($urandom());
    thr_set[5] = SB'($urandom());
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        write_reg(1'b0, thr_set[ph]);
        write_reg(1'b1, fall_set[ph]);
      end
      directed_band();
      for (int n = 0; n < 285; n++) begin
        send_item(rand_control(), rand_sample(), rand_sample(),
                  $urandom_range(0, 7) != 0);
        // Let the pipeline empty once mid-phase.
        if (n == 140) drain();
      end
      drain();
    end

    $display("Checked %0d results over %0d register writes, six threshold/falloff settings.",
             sb.results_seen, cfg_writes);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

[filelist.f]
rtl/tsb_pkg.sv
rtl/tsb_front.sv
rtl/tsb_fifo.sv
rtl/tsb_back.sv
rtl/threshold_smootherstep_blend.sv
dv/tb.sv
